@@ hw/rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame deframer with checksum.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned REG_IDX_W = 8;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_HEADER_BYTE = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEVICE_ID   = 8'd1;

	localparam logic [BYTE_W-1:0] HEADER_BYTE_RST = 8'd255;
	localparam logic [BYTE_W-1:0] DEVICE_ID_RST   = 8'd251;

	// frame length below which no checksum fits
	localparam logic [BYTE_W-1:0] MIN_LEN      = 8'd3;
	// length, type and checksum bytes are counted in the length
	localparam logic [BYTE_W-1:0] OVERHEAD_LEN = 8'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;

	typedef enum logic [5:0] {
		PH_HEAD = 6'b000001,
		PH_ID   = 6'b000010,
		PH_LEN  = 6'b000100,
		PH_TYPE = 6'b001000,
		PH_BODY = 6'b010000,
		PH_SUM  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  frame_type;
		logic [BYTE_W-1:0]  byte_index;
		logic [BYTE_W-1:0]  payload_byte;
		logic               is_last;
		logic [COUNT_W-1:0] good_frames;
	} result_t;

endpackage

@@ hw/rtl/sfd_if.sv @@
// ----------------------------------------------------------------------------
// sfd_if
// Channel interfaces of the deframer: received bytes, results, register writes.
// ----------------------------------------------------------------------------
interface sfd_rx_if;
	logic                        valid;
	logic                        ready;
	logic [sfd_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
	logic                        valid;
	logic                        ready;
	logic [sfd_pkg::KIND_W-1:0]  kind;
	logic [sfd_pkg::BYTE_W-1:0]  frame_type;
	logic [sfd_pkg::BYTE_W-1:0]  byte_index;
	logic [sfd_pkg::BYTE_W-1:0]  payload_byte;
	logic                        is_last;
	logic [sfd_pkg::COUNT_W-1:0] good_frames;

	modport source (output valid, output kind, output frame_type, output byte_index,
		output payload_byte, output is_last, output good_frames, input ready);
	modport sink   (input valid, input kind, input frame_type, input byte_index,
		input payload_byte, input is_last, input good_frames, output ready);
endinterface

interface sfd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sfd_pkg::REG_IDX_W-1:0] reg_index;
	logic [sfd_pkg::BYTE_W-1:0]    wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hw/rtl/serial_frame_deframer_checksum_core.sv @@
// ----------------------------------------------------------------------------
// serial_frame_deframer_checksum_core
// Hunts header and device id in a byte stream, forwards payload bytes and
// closes each frame with a checksum good/bad marker and a good-frame count.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per transaction (valid/ready).
//   res : zero or one result per byte: a payload byte (kind 0) or a frame
//         end marker (kind 1 good, kind 2 bad checksum) with the running
//         count of good frames.
//   cfg : register writes, index 0 header byte, index 1 device id; other
//         indexes are ignored. Always ready; write only while idle.
// Timing: a byte lands in an input register, is decoded there and its
// result is pushed into a two-entry output buffer, from which res valid
// rises. One byte per cycle is sustained while the output buffer has room,
// set by the single decode stage.
// Reset: hunting for a header, header 255, device id 251, counter zero,
// buffers empty.
// Stall: while res is stalled the output buffer fills; with both entries
// taken, the input register holds its byte and rx.ready falls until the
// receiver takes a result.
// ----------------------------------------------------------------------------
module serial_frame_deframer_checksum_core (
	input  logic        clk,
	input  logic        arst_n,
	sfd_rx_if.sink      rx,
	sfd_res_if.source   res,
	sfd_cfg_if.sink     cfg
);

	logic [sfd_pkg::BYTE_W-1:0]  header_q;
	logic [sfd_pkg::BYTE_W-1:0]  dev_id_q;

	logic                        valid_s1;
	logic [sfd_pkg::BYTE_W-1:0]  byte_s1;

	sfd_pkg::phase_t             phase_q, phase_d;
	logic [sfd_pkg::BYTE_W-1:0]  len_q, len_d;
	logic [sfd_pkg::BYTE_W-1:0]  type_q, type_d;
	logic [sfd_pkg::BYTE_W-1:0]  left_q, left_d;
	logic [sfd_pkg::BYTE_W-1:0]  sum_q, sum_d;
	logic [sfd_pkg::BYTE_W-1:0]  pos_q, pos_d;
	logic [sfd_pkg::COUNT_W-1:0] good_q, good_d;

	sfd_pkg::result_t            result;
	logic                        res_emit;

	// two-entry output buffer
	sfd_pkg::result_t            buf_q [2];
	logic                        wr_ptr_q, rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        buf_full;
	logic                        push, pop;
	logic                        advance;

	assign buf_full = (cnt_q == 2'd2);
	assign advance  = valid_s1 && !buf_full;
	assign rx.ready = !valid_s1 || !buf_full;
	assign push     = advance && res_emit;
	assign pop      = res.valid && res.ready;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= sfd_pkg::HEADER_BYTE_RST;
			dev_id_q <= sfd_pkg::DEVICE_ID_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				sfd_pkg::REG_HEADER_BYTE: header_q <= cfg.wdata;
				sfd_pkg::REG_DEVICE_ID:   dev_id_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// frame decode
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		type_d   = type_q;
		left_d   = left_q;
		sum_d    = sum_q;
		pos_d    = pos_q;
		good_d   = good_q;
		res_emit = 1'b0;
		result.kind         = sfd_pkg::KIND_PAYLOAD;
		result.frame_type   = type_q;
		result.byte_index   = '0;
		result.payload_byte = '0;
		result.is_last      = 1'b0;
		result.good_frames  = good_q;

		unique case (phase_q)
			sfd_pkg::PH_HEAD: begin
				phase_d = (byte_s1 == header_q) ? sfd_pkg::PH_ID : sfd_pkg::PH_HEAD;
			end
			sfd_pkg::PH_ID: begin
				phase_d = (byte_s1 == dev_id_q) ? sfd_pkg::PH_LEN : sfd_pkg::PH_HEAD;
			end
			sfd_pkg::PH_LEN: begin
				len_d   = byte_s1;
				phase_d = sfd_pkg::PH_TYPE;
			end
			sfd_pkg::PH_TYPE: begin
				type_d = byte_s1;
				if (len_q < sfd_pkg::MIN_LEN) begin
					phase_d = sfd_pkg::PH_HEAD;
				end else begin
					sum_d   = len_q + byte_s1;
					left_d  = len_q - sfd_pkg::OVERHEAD_LEN;
					pos_d   = '0;
					phase_d = (len_q == sfd_pkg::MIN_LEN) ? sfd_pkg::PH_SUM : sfd_pkg::PH_BODY;
				end
			end
			sfd_pkg::PH_BODY: begin
				sum_d               = sum_q + byte_s1;
				res_emit            = 1'b1;
				result.byte_index   = pos_q;
				result.payload_byte = byte_s1;
				pos_d               = pos_q + 8'd1;
				left_d              = left_q - 8'd1;
				if (left_q == 8'd1) begin
					phase_d = sfd_pkg::PH_SUM;
				end
			end
			sfd_pkg::PH_SUM: begin
				res_emit       = 1'b1;
				result.is_last = 1'b1;
				if (byte_s1 == sum_q) begin
					good_d      = good_q + 32'd1;
					result.kind = sfd_pkg::KIND_END_GOOD;
				end else begin
					result.kind = sfd_pkg::KIND_END_BAD;
				end
				result.good_frames = good_d;
				phase_d = sfd_pkg::PH_HEAD;
			end
			default: begin
				phase_d = sfd_pkg::PH_HEAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HEAD;
			len_q   <= '0;
			type_q  <= '0;
			left_q  <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
			good_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			type_q  <= type_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			pos_q   <= pos_d;
			good_q  <= good_d;
		end
	end

	// output buffer
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign res.valid        = (cnt_q != 2'd0);
	assign res.kind         = buf_q[rd_ptr_q].kind;
	assign res.frame_type   = buf_q[rd_ptr_q].frame_type;
	assign res.byte_index   = buf_q[rd_ptr_q].byte_index;
	assign res.payload_byte = buf_q[rd_ptr_q].payload_byte;
	assign res.is_last      = buf_q[rd_ptr_q].is_last;
	assign res.good_frames  = buf_q[rd_ptr_q].good_frames;

endmodule

@@ dv/sfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Watches the byte, result and register channels of the deframer, tracks the
// frame state and the good-frame count on its own, and compares every result
// transaction field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module sfd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rx_valid,
	input  logic                        rx_ready,
	input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [sfd_pkg::KIND_W-1:0]  res_kind,
	input  logic [sfd_pkg::BYTE_W-1:0]  res_frame_type,
	input  logic [sfd_pkg::BYTE_W-1:0]  res_byte_index,
	input  logic [sfd_pkg::BYTE_W-1:0]  res_payload_byte,
	input  logic                        res_is_last,
	input  logic [sfd_pkg::COUNT_W-1:0] res_good_frames,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [sfd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [sfd_pkg::BYTE_W-1:0]  cfg_wdata,
	output int                          errors,
	output int                          pending
);

	logic [sfd_pkg::BYTE_W-1:0]  hdr_value;
	logic [sfd_pkg::BYTE_W-1:0]  id_value;
	sfd_pkg::phase_t             hunt_state;
	logic [sfd_pkg::BYTE_W-1:0]  frame_len;
	logic [sfd_pkg::BYTE_W-1:0]  frame_type;
	logic [sfd_pkg::BYTE_W-1:0]  bytes_left;
	logic [sfd_pkg::BYTE_W-1:0]  csum;
	logic [sfd_pkg::BYTE_W-1:0]  pay_index;
	logic [sfd_pkg::COUNT_W-1:0] good_count;
	sfd_pkg::result_t            expected_results[$];
	sfd_pkg::result_t            oldest;

	initial errors = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// one received byte through the frame state machine
	task automatic advance_deframer(input logic [sfd_pkg::BYTE_W-1:0] b);
		sfd_pkg::result_t r;
		logic             hit;
		r = '0;
		hit = 1'b0;
		case (hunt_state)
			sfd_pkg::PH_HEAD:
				hunt_state = (b == hdr_value) ? sfd_pkg::PH_ID : sfd_pkg::PH_HEAD;
			sfd_pkg::PH_ID:
				hunt_state = (b == id_value) ? sfd_pkg::PH_LEN : sfd_pkg::PH_HEAD;
			sfd_pkg::PH_LEN: begin
				frame_len = b;
				hunt_state = sfd_pkg::PH_TYPE;
			end
			sfd_pkg::PH_TYPE: begin
				frame_type = b;
				if (frame_len < sfd_pkg::MIN_LEN) begin
					// no room for a checksum, drop quietly
					hunt_state = sfd_pkg::PH_HEAD;
				end else begin
					csum = frame_len + b;
					bytes_left = frame_len - sfd_pkg::OVERHEAD_LEN;
					pay_index = '0;
					hunt_state = (bytes_left == 0) ? sfd_pkg::PH_SUM : sfd_pkg::PH_BODY;
				end
			end
			sfd_pkg::PH_BODY: begin
				csum = csum + b;
				r.kind = sfd_pkg::KIND_PAYLOAD;
				r.frame_type = frame_type;
				r.byte_index = pay_index;
				r.payload_byte = b;
				r.is_last = 1'b0;
				r.good_frames = good_count;
				expected_results = {expected_results, r};
				pay_index = pay_index + 1'b1;
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0)
					hunt_state = sfd_pkg::PH_SUM;
			end
			sfd_pkg::PH_SUM: begin
				hit = (b == csum);
				if (hit)
					good_count = good_count + 1'b1;
				r.kind = hit ? sfd_pkg::KIND_END_GOOD : sfd_pkg::KIND_END_BAD;
				r.frame_type = frame_type;
				r.is_last = 1'b1;
				r.good_frames = good_count;
				expected_results = {expected_results, r};
				hunt_state = sfd_pkg::PH_HEAD;
			end
			default: hunt_state = sfd_pkg::PH_HEAD;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_value = sfd_pkg::HEADER_BYTE_RST;
			id_value = sfd_pkg::DEVICE_ID_RST;
			hunt_state = sfd_pkg::PH_HEAD;
			frame_len = '0;
			frame_type = '0;
			bytes_left = '0;
			csum = '0;
			pay_index = '0;
			good_count = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result transaction", res_kind, 0);
				end else begin
					oldest = expected_results.pop_front();
					compare_field("kind", res_kind, oldest.kind);
					compare_field("frame_type", res_frame_type, oldest.frame_type);
					compare_field("byte_index", res_byte_index, oldest.byte_index);
					compare_field("payload_byte", res_payload_byte, oldest.payload_byte);
					compare_field("is_last", res_is_last, oldest.is_last);
					compare_field("good_frames", res_good_frames, oldest.good_frames);
				end
			end
			if (cfg_valid && cfg_ready) begin
				// other indexes are dropped by the block
				if (cfg_index == sfd_pkg::REG_HEADER_BYTE)
					hdr_value = cfg_wdata;
				else if (cfg_index == sfd_pkg::REG_DEVICE_ID)
					id_value = cfg_wdata;
			end
			if (rx_valid && rx_ready)
				advance_deframer(rx_byte);
			pending <= expected_results.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression of the serial frame deframer: directed frames and hunting cases,
// then random well-formed and broken frames under several header/id settings,
// with bursty byte traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 290;
	// indexes the block must ignore
	localparam logic [sfd_pkg::REG_IDX_W-1:0] REG_SPARE = 8'd2;
	localparam logic [sfd_pkg::REG_IDX_W-1:0] REG_TOP   = 8'hFF;

	logic                       clk;
	logic                       arst_n;
	int                         errors;
	int                         pending;
	int                         idle_cycles = 0;
	int                         items_sent;
	int                         burst_left;
	bit                         long_hold;
	logic [sfd_pkg::BYTE_W-1:0] hdr_cur;
	logic [sfd_pkg::BYTE_W-1:0] id_cur;
	logic [sfd_pkg::BYTE_W-1:0] directed_bytes [24];
	int                         rx_mode;
	int                         rx_span;

	sfd_rx_if  rx_ch ();
	sfd_res_if res_ch ();
	sfd_cfg_if cfg_ch ();

	serial_frame_deframer_checksum_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	sfd_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx_valid         (rx_ch.valid),
		.rx_ready         (rx_ch.ready),
		.rx_byte          (rx_ch.rx_byte),
		.res_valid        (res_ch.valid),
		.res_ready        (res_ch.ready),
		.res_kind         (res_ch.kind),
		.res_frame_type   (res_ch.frame_type),
		.res_byte_index   (res_ch.byte_index),
		.res_payload_byte (res_ch.payload_byte),
		.res_is_last      (res_ch.is_last),
		.res_good_frames  (res_ch.good_frames),
		.cfg_valid        (cfg_ch.valid),
		.cfg_ready        (cfg_ch.ready),
		.cfg_index        (cfg_ch.reg_index),
		.cfg_wdata        (cfg_ch.wdata),
		.errors           (errors),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("serial_frame_deframer_checksum_core regression: fail");
			$finish;
		end
	end

	// result receiver: stall pattern changes every span; one long hold on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			rx_mode = $urandom_range(0, 3);
			rx_span = $urandom_range(16, 96);
			repeat (rx_span) begin
				@(posedge clk);
				if (long_hold) begin
					res_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					long_hold = 1'b0;
				end
				case (rx_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 1) == 0);
					2: res_ch.ready <= ($urandom_range(0, 9) != 0);
					default: res_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] len, input bit bad_sum);
		logic [sfd_pkg::BYTE_W-1:0] ftype;
		logic [sfd_pkg::BYTE_W-1:0] sum;
		logic [sfd_pkg::BYTE_W-1:0] pay;
		ftype = 8'($urandom);
		sum = len + ftype;
		send_byte(hdr_cur);
		send_byte(id_cur);
		send_byte(len);
		send_byte(ftype);
		for (int i = 3; i < len; i++) begin
			pay = 8'($urandom);
			sum = sum + pay;
			send_byte(pay);
		end
		if (bad_sum)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	task automatic send_random_unit();
		int                         pick;
		int                         n;
		logic [sfd_pkg::BYTE_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			len = ($urandom_range(0, 39) == 0) ? 8'd255 : 8'($urandom_range(3, 24));
			send_frame(len, $urandom_range(0, 3) == 0);
		end else if (pick < 78) begin
			// length too short for a checksum
			send_byte(hdr_cur);
			send_byte(id_cur);
			send_byte(8'($urandom_range(0, 2)));
			send_byte(8'($urandom));
		end else if (pick < 85) begin
			send_byte(hdr_cur);
			send_byte(8'($urandom));
		end else if (pick < 92) begin
			// cut short; the following bytes land in its body
			send_byte(hdr_cur);
			send_byte(id_cur);
			send_byte(8'($urandom_range(10, 40)));
			send_byte(8'($urandom));
			n = $urandom_range(0, 6);
			repeat (n) send_byte(8'($urandom));
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) send_byte(8'($urandom));
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_random_unit();
	endtask

	// drain results; a byte with no result may still be in flight after that
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// raises valid and leaves it high so writes can follow back to back
	task automatic write_reg(input logic [sfd_pkg::REG_IDX_W-1:0] idx,
			input logic [sfd_pkg::BYTE_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx == sfd_pkg::REG_HEADER_BYTE)
			hdr_cur = value;
		else if (idx == sfd_pkg::REG_DEVICE_ID)
			id_cur = value;
	endtask

	task automatic apply_config(input logic [sfd_pkg::BYTE_W-1:0] hdr,
			input logic [sfd_pkg::BYTE_W-1:0] id);
		settle();
		write_reg(REG_SPARE, ~hdr);
		write_reg(sfd_pkg::REG_HEADER_BYTE, hdr);
		write_reg(REG_TOP, ~id);
		write_reg(sfd_pkg::REG_DEVICE_ID, id);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = '0;
		cfg_ch.wdata = '0;
		arst_n = 1'b0;
		hdr_cur = sfd_pkg::HEADER_BYTE_RST;
		id_cur = sfd_pkg::DEVICE_ID_RST;
		burst_left = 0;
		items_sent = 0;
		long_hold = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte; header twice so the id check fails and the id is not a header;
		// lengths 0 and 2 dropped; length 3 good; length 5 with a bad checksum
		directed_bytes = '{8'h00,
			hdr_cur, hdr_cur, id_cur,
			hdr_cur, id_cur, 8'd0, 8'h11,
			hdr_cur, id_cur, 8'd2, 8'h22,
			hdr_cur, id_cur, 8'd3, 8'hFF, 8'h02,
			hdr_cur, id_cur, 8'd5, 8'h80, 8'h00, 8'hFF, 8'h85};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		apply_config(8'h00, 8'hFF);
		run_random(PHASE_ITEMS);

		apply_config(8'hFF, 8'h00);
		long_hold = 1'b1;
		send_frame(8'd60, 1'b0);
		run_random(PHASE_ITEMS);

		apply_config(8'h5A, 8'h5A);
		run_random(PHASE_ITEMS);

		apply_config(8'($urandom), 8'($urandom));
		run_random(PHASE_ITEMS);

		apply_config(sfd_pkg::HEADER_BYTE_RST, sfd_pkg::DEVICE_ID_RST);
		run_random(PHASE_ITEMS);

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("serial_frame_deframer_checksum_core regression: pass");
		else
			$display("serial_frame_deframer_checksum_core regression: fail");
		$finish;
	end

endmodule
